@@ rtl/core/apqa_pkg.sv @@
// Shared types and constants for the aging priority queue arbiter.
package apqa_pkg;

  localparam int unsigned MsgW   = 16;
  localparam int unsigned PrioW  = 4;
  localparam int unsigned TimeW  = 48;
  localparam int unsigned CapW   = 5;
  localparam int unsigned AgeW   = 16;
  localparam int unsigned ScoreW = 64;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CapW-1:0] CapReset = 5'd16;
  localparam logic [AgeW-1:0] AgeReset = 16'd256;
  localparam logic [ScoreW-1:0] ScoreUnit = 64'd256000;
  localparam logic [ScoreW-1:0] NeverBonus = 64'd1000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BUCKET_CAPACITY = 1'b0,
    CFG_AGING_FACTOR    = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CMP,
    ST_RD,
    ST_OUT
  } back_state_e;

  // One decoded transaction as it travels from the front end to the back end.
  typedef struct packed {
    func_e             func;
    logic              lvl_ok;
    logic [MsgW-1:0]   msg;
    logic [PrioW-1:0]  prio;
    logic [TimeW-1:0]  now;
  } cmd_t;

endpackage

@@ rtl/core/apqa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module apqa_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/apqa_front.sv @@
// Front end: accepts transactions, decodes them and buffers them in a short queue.
module apqa_front #(
  parameter int unsigned LEVELS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       func_i,
  input  logic [apqa_pkg::MsgW-1:0]  msg_index_i,
  input  logic [apqa_pkg::PrioW-1:0] priority_req_i,
  input  logic [apqa_pkg::TimeW-1:0] now_us_i,
  output logic                       cmd_valid_o,
  output apqa_pkg::cmd_t             cmd_o,
  input  logic                       cmd_ready_i
);
  import apqa_pkg::*;

  cmd_t       buf_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  cmd_t       cmd_new;

  always_comb begin
    cmd_new.func   = func_e'(func_i);
    cmd_new.lvl_ok = (32'(priority_req_i) < LEVELS);
    cmd_new.msg    = msg_index_i;
    cmd_new.prio   = priority_req_i;
    cmd_new.now    = now_us_i;
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = buf_q[rptr_q];

  always_comb begin
    wptr_d = push ? ~wptr_q : wptr_q;
    rptr_d = pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wptr_q] <= cmd_new;
    end
  end

endmodule

@@ rtl/core/apqa_back.sv @@
// Back end: per-level queue bookkeeping, aged scoring scan and result register.
module apqa_back #(
  parameter int unsigned LEVELS      = 8,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [apqa_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [apqa_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          cmd_valid_i,
  input  apqa_pkg::cmd_t                cmd_i,
  output logic                          cmd_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          ok_o,
  output logic [apqa_pkg::MsgW-1:0]     out_index_o,
  output logic [apqa_pkg::PrioW-1:0]    out_priority_o
);
  import apqa_pkg::*;

  localparam int unsigned LW = $clog2(LEVELS);
  localparam int unsigned DW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AW = $clog2(LEVELS * QUEUE_DEPTH);
  localparam int unsigned HalfW = TimeW / 2;
  localparam int unsigned PpW = HalfW + AgeW;

  back_state_e state_q, state_d;

  logic [CapW-1:0]  cap_q;
  logic [AgeW-1:0]  age_q;
  logic [DW-1:0]    head_q [LEVELS];
  logic [CW-1:0]    count_q [LEVELS];
  logic [TimeW-1:0] last_q [LEVELS];
  logic [LEVELS-1:0] active_q;

  logic [LW-1:0]     idx_q, idx_d;
  logic [LW-1:0]     best_q, best_d;
  logic              found_q, found_d;
  logic [ScoreW-1:0] best_score_q, best_score_d;
  logic [PpW-1:0]    pph_q, pph_d, ppl_q, ppl_d;
  logic [TimeW-1:0]  now_q, now_d;

  logic             out_valid_q, out_valid_d;
  logic             ok_q, ok_d;
  logic [MsgW-1:0]  oidx_q, oidx_d;
  logic [PrioW-1:0] oprio_q, oprio_d;

  logic             out_free;
  logic             last_idx;
  logic [LW-1:0]    sel_lvl;
  logic [DW-1:0]    sel_head;
  logic [CW-1:0]    sel_count;
  logic [DW+1:0]    slot_sum;
  logic [DW-1:0]    slot;
  logic             full;
  logic             do_push, do_pop_out;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [MsgW-1:0]  ram_rdata;
  logic [TimeW-1:0] wait_us;
  logic [ScoreW-1:0] base_s, aged, score;
  logic [ScoreW:0]   sum;
  logic [DW-1:0]    head_inc;

  assign out_free = !out_valid_q || !out_stall_i;
  assign last_idx = (idx_q == LW'(LEVELS - 1));

  // Head and count are read at one level at a time.
  assign sel_lvl   = (state_q == ST_IDLE) ? cmd_i.prio[LW-1:0] : best_q;
  assign sel_head  = head_q[sel_lvl];
  assign sel_count = count_q[sel_lvl];

  assign slot_sum = (DW+2)'(sel_head) + (DW+2)'(sel_count);
  assign slot = (32'(slot_sum) >= QUEUE_DEPTH) ? DW'(32'(slot_sum) - QUEUE_DEPTH)
                                               : DW'(slot_sum);
  assign head_inc = (32'(sel_head) + 1 == QUEUE_DEPTH) ? '0 : DW'(32'(sel_head) + 1);
  assign full = (32'(sel_count) >= 32'(cap_q)) || (32'(sel_count) >= QUEUE_DEPTH);

  assign do_push = (state_q == ST_IDLE) && cmd_valid_i && out_free &&
                   (cmd_i.func == FUNC_PUSH) && cmd_i.lvl_ok && !full;
  assign do_pop_out = (state_q == ST_OUT);

  assign ram_we    = do_push;
  assign ram_waddr = AW'(32'(sel_lvl) * QUEUE_DEPTH + 32'(slot));
  assign ram_raddr = AW'(32'(best_q) * QUEUE_DEPTH + 32'(sel_head));

  apqa_ram #(
    .Width(MsgW),
    .Depth(LEVELS * QUEUE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(cmd_i.msg),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Scoring datapath: each level is scored over the ST_MUL and ST_CMP states.
  assign wait_us = (now_q >= last_q[idx_q]) ? now_q - last_q[idx_q] : '0;
  assign base_s  = ScoreW'(LEVELS - 32'(idx_q));
  assign aged    = ScoreW'({pph_q, HalfW'(0)}) + ScoreW'(ppl_q);
  assign sum     = (ScoreW+1)'(base_s * ScoreUnit) + (ScoreW+1)'(aged);
  always_comb begin
    if (last_q[idx_q] == '0) begin
      score = (base_s + NeverBonus) * ScoreUnit;
    end else if (sum[ScoreW]) begin
      score = '1;
    end else begin
      score = sum[ScoreW-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && out_free && cmd_i.func == FUNC_POP && active_q != '0) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: state_d = ST_CMP;
      ST_CMP: state_d = last_idx ? ST_RD : ST_MUL;
      ST_RD:  state_d = ST_OUT;
      ST_OUT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    cmd_ready_o  = 1'b0;
    idx_d        = idx_q;
    best_d       = best_q;
    found_d      = found_q;
    best_score_d = best_score_q;
    pph_d        = pph_q;
    ppl_d        = ppl_q;
    now_d        = now_q;
    out_valid_d  = out_valid_q && out_stall_i;
    ok_d         = ok_q;
    oidx_d       = oidx_q;
    oprio_d      = oprio_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_ready_o = 1'b1;
          now_d   = cmd_i.now;
          idx_d   = '0;
          found_d = 1'b0;
          if (cmd_i.func == FUNC_PUSH || active_q == '0) begin
            out_valid_d = 1'b1;
            ok_d        = do_push;
            oidx_d      = '0;
            oprio_d     = '0;
          end
        end
      end
      ST_MUL: begin
        pph_d = PpW'(wait_us[TimeW-1:HalfW]) * PpW'(age_q);
        ppl_d = PpW'(wait_us[HalfW-1:0]) * PpW'(age_q);
      end
      ST_CMP: begin
        if (active_q[idx_q] && (!found_q || score > best_score_q)) begin
          found_d      = 1'b1;
          best_d       = idx_q;
          best_score_d = score;
        end
        if (!last_idx) begin
          idx_d = idx_q + LW'(1);
        end
      end
      ST_RD: begin
      end
      ST_OUT: begin
        out_valid_d = 1'b1;
        ok_d        = 1'b1;
        oidx_d      = ram_rdata;
        oprio_d     = PrioW'(best_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CapReset;
      age_q       <= AgeReset;
      active_q    <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
        last_q[i]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_BUCKET_CAPACITY: cap_q <= cfg_data_i[CapW-1:0];
          CFG_AGING_FACTOR:    age_q <= cfg_data_i[AgeW-1:0];
          default: begin
          end
        endcase
      end
      if (do_push) begin
        count_q[sel_lvl]  <= sel_count + CW'(1);
        active_q[sel_lvl] <= 1'b1;
      end
      if (do_pop_out) begin
        head_q[sel_lvl]  <= head_inc;
        count_q[sel_lvl] <= sel_count - CW'(1);
        last_q[sel_lvl]  <= now_q;
        if (sel_count == CW'(1)) begin
          active_q[sel_lvl] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    best_q       <= best_d;
    found_q      <= found_d;
    best_score_q <= best_score_d;
    pph_q        <= pph_d;
    ppl_q        <= ppl_d;
    now_q        <= now_d;
    ok_q         <= ok_d;
    oidx_q       <= oidx_d;
    oprio_q      <= oprio_d;
  end

  assign out_valid_o    = out_valid_q;
  assign ok_o           = ok_q;
  assign out_index_o    = oidx_q;
  assign out_priority_o = oprio_q;

endmodule

@@ rtl/core/aging_priority_queue_arbiter.sv @@
// Top level of the aging priority queue arbiter.
// The arbiter keeps one first-in first-out queue of 16-bit message indices for each of
// LEVELS priority levels (level 0 most urgent), each up to QUEUE_DEPTH deep and further
// limited by the bucket capacity register. A push transaction appends a message to its
// level; a pop transaction scores every non-empty level, combining its urgency with the
// time it has waited since last served weighted by the aging factor register, and returns
// the head of the best level, the lowest level winning ties. Every transaction yields
// exactly one result transaction. Accepted transactions wait in a two-entry queue in the
// front end while the back end works, so the input side can take two more transactions
// during a pop before it stalls. A push, or a pop with nothing queued, is answered from
// the back end's idle state; a pop that finds work runs a scan that scores each level in
// a multiply step (wait times aging factor) and then an add-and-compare step, followed
// by the registered read of the message store. No clearing pass runs after reset.
module aging_priority_queue_arbiter #(
  parameter int unsigned LEVELS      = 8,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [apqa_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [apqa_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          func_i,
  input  logic [apqa_pkg::MsgW-1:0]     msg_index_i,
  input  logic [apqa_pkg::PrioW-1:0]    priority_req_i,
  input  logic [apqa_pkg::TimeW-1:0]    now_us_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          ok_o,
  output logic [apqa_pkg::MsgW-1:0]     out_index_o,
  output logic [apqa_pkg::PrioW-1:0]    out_priority_o
);
  import apqa_pkg::*;

  // The decoded transaction at the head of the front-end queue.
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  apqa_front #(
    .LEVELS(LEVELS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .msg_index_i   (msg_index_i),
    .priority_req_i(priority_req_i),
    .now_us_i      (now_us_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_ready_i   (cmd_ready)
  );

  // The back end owns the queue state, the configuration registers and the result register.
  apqa_back #(
    .LEVELS     (LEVELS),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_ready_o   (cmd_ready),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .ok_o          (ok_o),
    .out_index_o   (out_index_o),
    .out_priority_o(out_priority_o)
  );

endmodule

@@ rtl/core/apqa_checker.sv @@
// Port-level checker for the aging priority queue arbiter, with its bind.
module apqa_checker #(
  parameter int unsigned LEVELS = 8
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic                       ok_o,
  input logic [apqa_pkg::MsgW-1:0]  out_index_o,
  input logic [apqa_pkg::PrioW-1:0] out_priority_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(ok_o) && $stable(out_index_o)
                                   && $stable(out_priority_o))
    else $error("stalled result changed");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> out_index_o == '0 && out_priority_o == '0)
    else $error("failed result carries data");

  a_prio_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(out_priority_o) < LEVELS)
    else $error("result level out of range");

endmodule

bind aging_priority_queue_arbiter apqa_checker #(
  .LEVELS(LEVELS)
) u_apqa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .ok_o          (ok_o),
  .out_index_o   (out_index_o),
  .out_priority_o(out_priority_o)
);

@@ sim/tb_aging_priority_queue_arbiter.sv @@
// Self-checking testbench for the aging priority queue arbiter.
module tb_aging_priority_queue_arbiter;
  import apqa_pkg::*;

  localparam int unsigned NumLevels = 8;
  localparam int unsigned Depth     = 16;
  // Margin for a pop that finds work to finish in the back end.
  localparam int unsigned PopCycles = 2 * NumLevels + 3;

  // One expected result transaction.
  typedef struct {
    logic             ok;
    logic [MsgW-1:0]  index;
    logic [PrioW-1:0] prio;
  } result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                func_i;
  logic [MsgW-1:0]     msg_index_i;
  logic [PrioW-1:0]    priority_req_i;
  logic [TimeW-1:0]    now_us_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                ok_o;
  logic [MsgW-1:0]     out_index_o;
  logic [PrioW-1:0]    out_priority_o;

  aging_priority_queue_arbiter #(
    .LEVELS     (NumLevels),
    .QUEUE_DEPTH(Depth)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .msg_index_i   (msg_index_i),
    .priority_req_i(priority_req_i),
    .now_us_i      (now_us_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .ok_o          (ok_o),
    .out_index_o   (out_index_o),
    .out_priority_o(out_priority_o)
  );

  // The predictor's own copy of the arbiter state and its registers.
  logic [CapW-1:0]  cap_reg;
  logic [AgeW-1:0]  age_reg;
  logic [MsgW-1:0]  fifo_mem [NumLevels][Depth];
  int unsigned      fifo_head [NumLevels];
  int unsigned      fifo_fill [NumLevels];
  logic [TimeW-1:0] served_at [NumLevels];

  result_t pending_results[$];
  int unsigned error_count;
  int unsigned sent_count;
  int unsigned checked_count;
  int unsigned pop_hits;
  int unsigned push_rejects;
  int unsigned burst_left;
  logic [TimeW-1:0] clock_us;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("Verification failed");
    $finish;
  end

  // Scores one level exactly as the hardware should: 64-bit, saturating on the sum of base and aged terms.
  function automatic logic [ScoreW-1:0] level_priority_score(int unsigned lvl,
                                                             logic [TimeW-1:0] now);
    logic [ScoreW-1:0] base;
    logic [ScoreW-1:0] waited;
    logic [ScoreW:0]   total;
    base = ScoreW'(NumLevels - lvl);
    if (served_at[lvl] == '0) return (base + NeverBonus) * ScoreUnit;
    waited = (now >= served_at[lvl]) ? ScoreW'(now - served_at[lvl]) : '0;
    total = {1'b0, base * ScoreUnit} + {1'b0, waited * ScoreW'(age_reg)};
    return total[ScoreW] ? '1 : total[ScoreW-1:0];
  endfunction

  // Works out the result of one transaction and advances the predicted state.
  function automatic result_t arbitrate(func_e op, logic [MsgW-1:0] msg,
                                        logic [PrioW-1:0] lvl, logic [TimeW-1:0] now);
    result_t r;
    int unsigned limit;
    int best;
    logic [ScoreW-1:0] best_score;
    logic [ScoreW-1:0] s;
    r = '{ok: 1'b0, index: '0, prio: '0};
    if (op == FUNC_PUSH) begin
      limit = (cap_reg < Depth) ? cap_reg : Depth;
      if (lvl >= NumLevels || fifo_fill[lvl] >= limit) begin
        push_rejects++;
        return r;
      end
      fifo_mem[lvl][(fifo_head[lvl] + fifo_fill[lvl]) % Depth] = msg;
      fifo_fill[lvl]++;
      r.ok = 1'b1;
      return r;
    end
    best = -1;
    best_score = '0;
    for (int l = 0; l < NumLevels; l++) begin
      if (fifo_fill[l] != 0) begin
        s = level_priority_score(l, now);
        if (best < 0 || s > best_score) begin
          best = l;
          best_score = s;
        end
      end
    end
    if (best < 0) return r;
    r.ok = 1'b1;
    r.index = fifo_mem[best][fifo_head[best]];
    r.prio = PrioW'(best);
    fifo_head[best] = (fifo_head[best] + 1) % Depth;
    fifo_fill[best]--;
    served_at[best] = now;
    pop_hits++;
    return r;
  endfunction

  // Receiver: stalls on its own pattern and checks each result transaction.
  initial begin
    result_t want;
    int unsigned stall_phase;
    out_stall_i = 1'b0;
    stall_phase = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        checked_count++;
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected: ok=%0b index=%0h prio=%0d",
                   $time, ok_o, out_index_o, out_priority_o);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (ok_o !== want.ok) begin
            $display("%0t: ok expected %0b actual %0b", $time, want.ok, ok_o);
            error_count++;
          end
          if (out_index_o !== want.index) begin
            $display("%0t: out_index expected %0h actual %0h", $time, want.index,
                     out_index_o);
            error_count++;
          end
          if (out_priority_o !== want.prio) begin
            $display("%0t: out_priority expected %0d actual %0d", $time, want.prio,
                     out_priority_o);
            error_count++;
          end
        end
      end
      // Quiet stretches alternate with stretches of heavy and light stalling.
      stall_phase++;
      case ((stall_phase / 200) % 3)
        0: begin
          out_stall_i <= 1'b0;
        end
        1: begin
          out_stall_i <= ($urandom_range(0, 99) < 60);
        end
        default: begin
          out_stall_i <= ($urandom_range(0, 99) < 15);
        end
      endcase
    end
  end

  // Sends one transaction, waits for its acceptance and records its expected result.
  task automatic send_transaction(func_e op, logic [MsgW-1:0] msg, logic [PrioW-1:0] lvl,
                                  logic [TimeW-1:0] now);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    func_i         <= op;
    msg_index_i    <= msg;
    priority_req_i <= lvl;
    now_us_i       <= now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(arbitrate(op, msg, lvl, now));
    sent_count++;
    // The valid stays high if the next transaction follows at once.
    if (burst_left == 0) in_valid_i <= 1'b0;
  endtask

  // Waits for every expected result, then lets the back end finish any pop.
  task automatic drain_results();
    // A burst still in progress has its valid high; drop it before the next edge.
    if (burst_left != 0) in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (PopCycles + 4) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [CfgDataW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_BUCKET_CAPACITY) cap_reg = value[CapW-1:0];
    else age_reg = value[AgeW-1:0];
    @(posedge clk_i);
  endtask

  // Pop that is guaranteed to use a fresh, nonzero time stamp.
  task automatic timed_pop(int unsigned advance);
    clock_us = clock_us + advance;
    send_transaction(FUNC_POP, MsgW'($urandom), PrioW'($urandom), clock_us);
  endtask

  // Extreme field values, out-of-range levels, empty pops and the zero stamp.
  task automatic test_directed_extremes();
    send_transaction(FUNC_POP, 16'hffff, 4'hf, '1);
    send_transaction(FUNC_PUSH, 16'h0000, 4'd0, '0);
    send_transaction(FUNC_PUSH, 16'hffff, 4'd7, '1);
    send_transaction(FUNC_PUSH, 16'ha5a5, 4'd8, '0);
    send_transaction(FUNC_PUSH, 16'h5a5a, 4'hf, '1);
    send_transaction(FUNC_PUSH, 16'h1234, 4'd3, 48'h5555_5555_5555);
    send_transaction(FUNC_POP, 16'h0000, 4'd0, '0);
    send_transaction(FUNC_POP, 16'hffff, 4'hf, 48'haaaa_aaaa_aaaa);
    send_transaction(FUNC_POP, 16'h0000, 4'd0, '1);
    send_transaction(FUNC_POP, 16'h0000, 4'd0, 48'd7);
    drain_results();
  endtask

  // Fills one level to capacity, overflows it, then lowers capacity below the fill.
  task automatic test_capacity_limits();
    write_register(CFG_BUCKET_CAPACITY, 16'd4);
    for (int i = 0; i < 6; i++) send_transaction(FUNC_PUSH, MsgW'(16'h100 + i), 4'd2, '0);
    drain_results();
    write_register(CFG_BUCKET_CAPACITY, 16'd1);
    send_transaction(FUNC_PUSH, 16'h0bad, 4'd2, '0);
    for (int i = 0; i < 5; i++) timed_pop(10);
    drain_results();
    write_register(CFG_BUCKET_CAPACITY, 16'd0);
    send_transaction(FUNC_PUSH, 16'h0bad, 4'd1, '0);
    drain_results();
    // Values above the depth are clipped to the depth.
    write_register(CFG_BUCKET_CAPACITY, 16'd31);
    for (int i = 0; i < 17; i++) send_transaction(FUNC_PUSH, MsgW'($urandom), 4'd5, '0);
    for (int i = 0; i < 17; i++) timed_pop(3);
    drain_results();
  endtask

  // Saturating scores with the largest aging factor and the widest waits.
  task automatic test_score_saturation();
    write_register(CFG_AGING_FACTOR, 16'hffff);
    send_transaction(FUNC_PUSH, 16'h0001, 4'd6, '0);
    send_transaction(FUNC_PUSH, 16'h0002, 4'd6, '0);
    send_transaction(FUNC_PUSH, 16'h0003, 4'd0, '0);
    send_transaction(FUNC_POP, 16'h0000, 4'd0, 48'd1);
    send_transaction(FUNC_POP, 16'h0000, 4'd0, 48'd2);
    send_transaction(FUNC_PUSH, 16'h0004, 4'd0, '0);
    send_transaction(FUNC_POP, 16'h0000, 4'd0, '1);
    send_transaction(FUNC_POP, 16'h0000, 4'd0, '1);
    drain_results();
    write_register(CFG_AGING_FACTOR, 16'd0);
  endtask

  // Mostly well-formed push and pop traffic with random content and varying settings.
  task automatic test_random_traffic(int unsigned count);
    int unsigned roll;
    logic [TimeW-1:0] stamp;
    for (int i = 0; i < count; i++) begin
      if (i % 400 == 399) begin
        drain_results();
        write_register(CFG_BUCKET_CAPACITY, CfgDataW'($urandom_range(0, 31)));
        write_register(CFG_AGING_FACTOR, ($urandom_range(0, 3) == 0) ?
                       CfgDataW'($urandom_range(0, 1) * 16'hffff) : CfgDataW'($urandom));
      end
      roll = $urandom_range(0, 99);
      clock_us = clock_us + $urandom_range(0, 5000);
      stamp = clock_us;
      if (roll < 4) stamp = TimeW'({$urandom, $urandom});
      else if (roll < 6) stamp = '0;
      if ($urandom_range(0, 99) < 52) begin
        send_transaction(FUNC_PUSH, MsgW'($urandom),
                         ($urandom_range(0, 9) == 0) ? PrioW'($urandom) :
                         PrioW'($urandom_range(0, NumLevels - 1)), stamp);
      end else begin
        send_transaction(FUNC_POP, MsgW'($urandom), PrioW'($urandom), stamp);
      end
    end
    drain_results();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_BUCKET_CAPACITY;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    func_i = FUNC_PUSH;
    msg_index_i = '0;
    priority_req_i = '0;
    now_us_i = '0;
    cap_reg = CapReset;
    age_reg = AgeReset;
    for (int l = 0; l < NumLevels; l++) begin
      fifo_head[l] = 0;
      fifo_fill[l] = 0;
      served_at[l] = '0;
    end
    error_count = 0;
    sent_count = 0;
    checked_count = 0;
    pop_hits = 0;
    push_rejects = 0;
    burst_left = 0;
    clock_us = 48'd1000;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_extremes();
    test_capacity_limits();
    test_score_saturation();
    write_register(CFG_BUCKET_CAPACITY, 16'd16);
    write_register(CFG_AGING_FACTOR, 16'd256);
    test_random_traffic(1700);

    $display("Sent %0d transactions, checked %0d results: %0d pops served, %0d pushes refused.",
             sent_count, checked_count, pop_hits, push_rejects);
    $display("Covered capacity limits, zero and saturated aging, empty pops and stamp reuse.");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
